// ===== design/ult_pkg.sv =====
// Shared constants for the unordered list table: word width, operation
// codes and status codes.
// No dependencies.
`default_nettype none

package ult_pkg;

  localparam int DATA_W = 32;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

endpackage

`default_nettype wire

// ===== design/ult_mem.sv =====
// Entry store of the unordered list table: one write port, one read port,
// read data registered.
// Depends on ult_pkg for the word width.
`default_nettype none

module ult_mem
  import ult_pkg::*;
#(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one entry, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/unordered_list_table.sv =====
// Unordered list table: fixed-capacity 1-indexed list of signed words.
// Insert moves the entry at the position to the end, then writes the new
// value there; remove writes the last entry over the matched one.
// Throughput: one beat at a time; the scan reads one stored entry per cycle
// through the single read port of the entry memory.
// Reset (rst, synchronous) clears the count and the control state; entries
// hold whatever was last written and need no clearing pass.
`default_nettype none

module unordered_list_table
  import ult_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [FUNC_W-1:0]                   func,
  input  wire logic signed [DATA_W-1:0]            value,
  input  wire logic [$clog2(CAPACITY+1)-1:0]       position,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [STAT_W-1:0]                        status,
  output logic [$clog2(CAPACITY+1)-1:0]            found_index,
  output logic [$clog2(CAPACITY+1)-1:0]            count_after
);

  localparam int IDX_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = IDX_W + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INS_MV = 3'd1;
  localparam logic [2:0] S_INS_WR = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_REM_RD = 3'd4;
  localparam logic [2:0] S_REM_WR = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]        state;
  logic [IDX_W-1:0]  count;
  logic [DATA_W-1:0] op_value;
  logic [ADDR_W-1:0] op_addr;
  logic              op_remove;
  logic [IDX_W-1:0]  ptr;
  logic              cmp_vld;
  logic [ADDR_W-1:0] cmp_idx;
  logic [STAT_W-1:0] res_status;
  logic [IDX_W-1:0]  res_index;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [DATA_W-1:0] mem_rdata;
  logic              accept;
  logic              out_free;
  logic              hit;
  logic              last_cmp;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign hit      = cmp_vld && (mem_rdata == op_value);
  assign last_cmp = cmp_vld && (cmp_idx == ADDR_W'(count - IDX_W'(1)));

  ult_mem #(
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Steer memory ports by state
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = op_addr;
    mem_wdata = op_value;
    mem_raddr = ADDR_W'(position - IDX_W'(1));
    unique case (state)
      S_SCAN:   mem_raddr = ptr[ADDR_W-1:0];
      S_REM_RD: mem_raddr = ADDR_W'(count - IDX_W'(1));
      S_INS_MV: begin
        mem_we    = 1'b1;
        mem_waddr = count[ADDR_W-1:0];
        mem_wdata = mem_rdata;
      end
      S_INS_WR: mem_we = 1'b1;
      S_REM_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
      end
      default: ;
    endcase
  end

  // Sequencer: decode, scan, read-modify-write, hand off result
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      cmp_vld <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          ptr     <= '0;
          cmp_vld <= 1'b0;
          if (accept) begin
            op_value   <= value;
            op_remove  <= (func == FUNC_REMOVE);
            op_addr    <= ADDR_W'(position - IDX_W'(1));
            res_index  <= '0;
            res_status <= ST_OK;
            state      <= S_DONE;
            if (func == FUNC_INSERT) begin
              if (count == IDX_W'(CAPACITY)) begin
                res_status <= ST_FULL;
              end else if (position == '0 ||
                           CNT_W'(position) > CNT_W'(count) + CNT_W'(1)) begin
                res_status <= ST_BADPOS;
              end else begin
                state <= S_INS_MV;
              end
            end else if (func == FUNC_SEARCH || func == FUNC_REMOVE) begin
              if (count == '0) begin
                res_status <= ST_NOTFOUND;
              end else begin
                state <= S_SCAN;
              end
            end else begin
              res_status <= ST_BADPOS;
            end
          end
        end
        S_INS_MV: state <= S_INS_WR;
        S_INS_WR: begin
          count <= count + IDX_W'(1);
          state <= S_DONE;
        end
        S_SCAN: begin
          ptr     <= ptr + IDX_W'(1);
          cmp_vld <= 1'b1;
          cmp_idx <= ptr[ADDR_W-1:0];
          if (hit) begin
            res_index <= IDX_W'(cmp_idx) + IDX_W'(1);
            op_addr   <= cmp_idx;
            state     <= op_remove ? S_REM_RD : S_DONE;
          end else if (last_cmp) begin
            res_status <= ST_NOTFOUND;
            state      <= S_DONE;
          end
        end
        S_REM_RD: state <= S_REM_WR;
        S_REM_WR: begin
          count <= count - IDX_W'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: load a finished beat, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      status      <= res_status;
      found_index <= res_index;
      count_after <= count;
    end
  end

  // Count stays within capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= IDX_W'(CAPACITY))
    else $error("entry count above capacity");

  // Memory writes only in the insert and remove write states
  a_we_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_INS_MV || state == S_INS_WR || state == S_REM_WR))
    else $error("memory write outside write states");

  // A scan never runs on an empty list
  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (count != '0))
    else $error("scan with empty list");

  // Insert commit grows the count by one
  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_WR) |=> (state == S_DONE && count == $past(count) + IDX_W'(1)))
    else $error("insert did not grow the count");

  // A match reported by the scan lies inside the live list
  a_hit_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && hit) |-> (IDX_W'(cmp_idx) < count))
    else $error("scan match beyond last entry");

endmodule

`default_nettype wire
